@@ rtl/utt_pkg.sv @@
// shared types and constants for the timer-stepped 8n1 uart transceiver
package utt_pkg;

   // register widths and reset values
   localparam int unsigned BIT_PERIOD_BITS  = 16;
   localparam int unsigned HALF_PERIOD_BITS = 15;
   localparam int unsigned CSR_DATA_BITS    = 16;
   localparam int unsigned CSR_INDEX_BITS   = 1;
   localparam logic [15:0] BIT_PERIOD_RESET  = 16'd104;
   localparam logic [14:0] HALF_PERIOD_RESET = 15'd52;

   // timer width range and the wide form used to resize load values
   localparam int unsigned TIMER_BITS_DEFAULT = 16;
   localparam int unsigned TIMER_BITS_MAX     = 32;
   localparam int unsigned LOAD_BITS          = TIMER_BITS_MAX + 1;

   // frame bit counts
   localparam logic [3:0] TX_FRAME_BITS = 4'd10;
   localparam logic [3:0] RX_DATA_BITS  = 4'd8;

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BIT_PERIOD  = 1'b0,
      CSR_HALF_PERIOD = 1'b1
   } csr_index_type;

   // per-tick transmitter result
   typedef struct packed {
      logic line;
      logic ready;
   } tx_result_type;

   // per-tick receiver result
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } rx_result_type;

endpackage

@@ rtl/utt_tx.sv @@
// transmitter: frames a byte as start, 8 data lsb first, stop, one bit per period
module utt_tx #(
   parameter int unsigned TIMER_BITS = utt_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   start,
   input  logic [7:0]             data,
   input  logic [15:0]            bit_period,
   output utt_pkg::tx_result_type result
);
   import utt_pkg::*;

   logic [9:0]            shift_ff, shift_in;
   logic [3:0]            bits_left_ff, bits_left_in;
   logic                  busy_ff, busy_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  level_ff, level_in;
   logic [LOAD_BITS-1:0]  load_wide;
   logic [TIMER_BITS-1:0] load;
   logic                  fire;

   // bit period resized to the timer width
   assign load_wide = LOAD_BITS'(bit_period);
   assign load      = load_wide[TIMER_BITS-1:0];
   assign fire      = (timer_ff[TIMER_BITS-1:1] == '0);

   // next state for one tick
   always_comb begin
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      busy_in      = busy_ff;
      timer_in     = timer_ff;
      level_in     = level_ff;
      if (!busy_ff) begin
         if (start) begin
            shift_in     = {1'b1, data, 1'b0};
            bits_left_in = TX_FRAME_BITS;
            busy_in      = 1'b1;
            timer_in     = load;
         end
      end else if (fire) begin
         timer_in = load;
         if (bits_left_ff == '0) begin
            busy_in      = 1'b0;
            bits_left_in = TX_FRAME_BITS;
         end else begin
            level_in     = shift_ff[0];
            shift_in     = {1'b0, shift_ff[9:1]};
            bits_left_in = bits_left_ff - 4'd1;
         end
      end else begin
         timer_in = timer_ff - TIMER_BITS'(1);
      end
   end

   // state registers, advanced once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         bits_left_ff <= TX_FRAME_BITS;
         busy_ff      <= 1'b0;
         timer_ff     <= '0;
         level_ff     <= 1'b1;
      end else if (step) begin
         shift_ff     <= shift_in;
         bits_left_ff <= bits_left_in;
         busy_ff      <= busy_in;
         timer_ff     <= timer_in;
         level_ff     <= level_in;
      end
   end

   // values after this tick's update
   assign result.line  = level_in;
   assign result.ready = !busy_in;

endmodule

@@ rtl/utt_rx.sv @@
// receiver: start edge detect, mid-bit sampling, 8 data bits lsb first
module utt_rx #(
   parameter int unsigned TIMER_BITS = utt_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   line,
   input  logic [15:0]            bit_period,
   input  logic [14:0]            half_bit_period,
   output utt_pkg::rx_result_type result
);
   import utt_pkg::*;

   logic [7:0]          shift_ff, shift_in;
   logic [3:0]          bits_left_ff, bits_left_in;
   logic                sampling_ff, sampling_in;
   logic [TIMER_BITS:0] timer_ff, timer_in;
   logic                last_level_ff;
   logic [7:0]          held_ff, held_in;
   logic                valid;
   logic [16:0]         first_sum;
   logic [LOAD_BITS-1:0] first_wide, period_wide;
   logic [TIMER_BITS:0] first_load, period_load;
   logic                fire;

   // load values resized to the timer width
   assign first_sum   = {1'b0, bit_period} + {2'b0, half_bit_period};
   assign first_wide  = LOAD_BITS'(first_sum);
   assign period_wide = LOAD_BITS'(bit_period);
   assign first_load  = first_wide[TIMER_BITS:0];
   assign period_load = period_wide[TIMER_BITS:0];
   assign fire        = (timer_ff[TIMER_BITS:1] == '0);

   // next state for one tick
   always_comb begin
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      sampling_in  = sampling_ff;
      timer_in     = timer_ff;
      held_in      = held_ff;
      valid        = 1'b0;
      if (!sampling_ff) begin
         if (last_level_ff && !line) begin
            sampling_in = 1'b1;
            timer_in    = first_load;
         end
      end else if (fire) begin
         timer_in     = period_load;
         shift_in     = {line, shift_ff[7:1]};
         bits_left_in = bits_left_ff - 4'd1;
         if (bits_left_in == '0) begin
            held_in      = shift_in;
            bits_left_in = RX_DATA_BITS;
            sampling_in  = 1'b0;
            valid        = 1'b1;
         end
      end else begin
         timer_in = timer_ff - (TIMER_BITS + 1)'(1);
      end
   end

   // state registers, advanced once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         bits_left_ff  <= RX_DATA_BITS;
         sampling_ff   <= 1'b0;
         timer_ff      <= '0;
         last_level_ff <= 1'b1;
         held_ff       <= '0;
      end else if (step) begin
         shift_ff      <= shift_in;
         bits_left_ff  <= bits_left_in;
         sampling_ff   <= sampling_in;
         timer_ff      <= timer_in;
         last_level_ff <= line;
         held_ff       <= held_in;
      end
   end

   assign result.valid = valid;
   assign result.data  = held_in;

endmodule

@@ rtl/uart_8n1_timer_transceiver.sv @@
// Top level of the timer-stepped 8n1 uart transceiver.
// Each req_ beat is one timer tick: the sampled receive line, a send request
// and the byte to send. Each tick yields exactly one rsp_ beat carrying the
// transmit line level, transmitter ready, a received-byte strobe and the
// last received byte, all as they stand after that tick.
// Ticks pass through an input register and then a result register, and one
// tick is taken every cycle while the result side keeps up.
// When the result side stalls, the result register holds its beat and the
// input register holds one more tick; req_ready drops only when both are full.
// The csr_ port writes bit_period (index 0) or half_bit_period (index 1), one
// register per write; write them only while no tick is in flight.
// Synchronous reset returns both registers to 104 and 52, the transmitter to
// idle with the line high and the receiver to waiting for a start edge.
module uart_8n1_timer_transceiver #(
   parameter int unsigned TIMER_BITS = utt_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_rx_line,
   input  logic                               req_tx_start,
   input  logic [7:0]                         req_tx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_tx_line,
   output logic                               rsp_tx_ready,
   output logic                               rsp_rx_valid,
   output logic [7:0]                         rsp_rx_byte,
   input  logic                               csr_we,
   input  logic [utt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [utt_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import utt_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic          in_rx_line_ff;
   logic          in_tx_start_ff;
   logic [7:0]    in_tx_byte_ff;
   logic          out_valid_ff, out_valid_in;
   logic          out_tx_line_ff;
   logic          out_tx_ready_ff;
   logic          out_rx_valid_ff;
   logic [7:0]    out_rx_byte_ff;
   logic [15:0]   bit_period_ff;
   logic [14:0]   half_period_ff;
   logic          advance;
   logic          accept;
   tx_result_type tx_result;
   rx_result_type rx_result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= BIT_PERIOD_RESET;
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIT_PERIOD:  bit_period_ff  <= csr_wdata[BIT_PERIOD_BITS-1:0];
            CSR_HALF_PERIOD: half_period_ff <= csr_wdata[HALF_PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_rx_line_ff  <= req_rx_line;
         in_tx_start_ff <= req_tx_start;
         in_tx_byte_ff  <= req_tx_byte;
      end
   end

   utt_tx #(
      .TIMER_BITS (TIMER_BITS)
   ) u_tx (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .start      (in_tx_start_ff),
      .data       (in_tx_byte_ff),
      .bit_period (bit_period_ff),
      .result     (tx_result)
   );

   utt_rx #(
      .TIMER_BITS (TIMER_BITS)
   ) u_rx (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .line            (in_rx_line_ff),
      .bit_period      (bit_period_ff),
      .half_bit_period (half_period_ff),
      .result          (rx_result)
   );

   // result register, keeps the latest tick's state after the beat leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         out_tx_line_ff  <= 1'b1;
         out_tx_ready_ff <= 1'b1;
         out_rx_valid_ff <= 1'b0;
         out_rx_byte_ff  <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            out_tx_line_ff  <= tx_result.line;
            out_tx_ready_ff <= tx_result.ready;
            out_rx_valid_ff <= rx_result.valid;
            out_rx_byte_ff  <= rx_result.data;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_tx_line  = out_tx_line_ff;
   assign rsp_tx_ready = out_tx_ready_ff;
   assign rsp_rx_valid = out_rx_valid_ff;
   assign rsp_rx_byte  = out_rx_byte_ff;

   // an empty input register never blocks a tick
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input register empty but req_ready low");

   // a tick that moves forward always lands in the result register
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced tick missing from result register");

   // a send request on an idle transmitter makes it busy
   a_start_takes_tx: assert property (@(posedge clock) disable iff (reset)
      advance && in_tx_start_ff && out_tx_ready_ff |=> !out_tx_ready_ff)
      else $error("send request on idle transmitter not taken");

endmodule

@@ tb/uart_8n1_timer_transceiver_test.sv @@
// self-checking testbench for the timer-stepped 8n1 uart transceiver
module uart_8n1_timer_transceiver_test;
   import utt_pkg::*;

   localparam int unsigned SETTLE_CYCLES  = 6;
   localparam int unsigned WATCHDOG_LIMIT = 500;
   localparam int unsigned DRILL_ROWS     = 17;
   localparam int unsigned DRILL_SPLIT    = 4;
   localparam int unsigned PHASE_COUNT    = 8;

   // one timer tick as driven on the req_ side
   typedef struct packed {
      logic       rx_line;
      logic       tx_start;
      logic [7:0] tx_byte;
   } tick_in_type;

   // line levels and strobes after one tick
   typedef struct packed {
      tx_result_type tx;
      rx_result_type rx;
   } line_state_type;

   // directed row: typed rows carry their own answer
   typedef struct packed {
      tick_in_type    stim;
      logic           typed;
      line_state_type want;
   } drill_row_type;

   // period setting and idling shape of one random phase
   typedef struct {
      logic [15:0] period;
      logic [15:0] half_word;
      int unsigned ticks;
      int unsigned max_gap;
      int unsigned hold_len;
      int unsigned hold_period;
   } phase_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   logic                 req_rx_line  = 1'b1;
   logic                 req_tx_start = 1'b0;
   logic [7:0]           req_tx_byte  = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   logic                 rsp_tx_line;
   logic                 rsp_tx_ready;
   logic                 rsp_rx_valid;
   logic [7:0]           rsp_rx_byte;
   logic                 csr_we       = 1'b0;
   csr_index_type        csr_index    = CSR_BIT_PERIOD;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // first rows at reset periods, the rest at one tick per bit
   drill_row_type drill [DRILL_ROWS] = '{
      '{'{1'b1, 1'b0, 8'h00}, 1'b1, '{'{1'b1, 1'b1}, '{1'b0, 8'h00}}},
      '{'{1'b1, 1'b1, 8'hFF}, 1'b1, '{'{1'b1, 1'b0}, '{1'b0, 8'h00}}},
      '{'{1'b1, 1'b1, 8'h00}, 1'b1, '{'{1'b1, 1'b0}, '{1'b0, 8'h00}}},
      '{'{1'b1, 1'b0, 8'h5A}, 1'b1, '{'{1'b1, 1'b0}, '{1'b0, 8'h00}}},
      // 0x5a frame: bit 6 high, bit 7 low, so the line falls on the last sample
      '{'{1'b1, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b0, 1'b1, 8'h00}, 1'b0, '0},
      '{'{1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b1, 1'b0, 8'hFF}, 1'b0, '0},
      '{'{1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b1, 1'b1, 8'h81}, 1'b0, '0},
      '{'{1'b1, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b1, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b0, 1'b0, 8'h00}, 1'b0, '0},
      '{'{1'b1, 1'b0, 8'h00}, 1'b0, '0}
   };

   phase_type phase_plan [PHASE_COUNT] = '{
      '{16'd2,     16'd1,      200, 3, 0, 1},
      '{16'd1,     16'd0,      140, 0, 2, 5},
      '{16'd0,     16'd0,      100, 5, 4, 9},
      '{16'd3,     16'd1,      150, 2, 1, 3},
      '{16'd5,     16'd2,      140, 0, 0, 1},
      '{16'd16,    16'd8,      140, 4, 7, 11},
      '{16'd4,     16'd2,      60,  1, 3, 7},
      '{16'd65535, 16'hFFFF,   40,  1, 3, 4}
   };

   // predicted transceiver state, timers 16 bits for tx and 17 for rx
   logic [15:0] period_ticks = BIT_PERIOD_RESET;
   logic [14:0] half_ticks   = HALF_PERIOD_RESET;
   logic [9:0]  xmit_frame   = '0;
   logic [3:0]  xmit_bits    = TX_FRAME_BITS;
   logic        xmit_busy    = 1'b0;
   logic [15:0] xmit_count   = '0;
   logic        xmit_level   = 1'b1;
   logic [7:0]  recv_shift   = '0;
   logic [3:0]  recv_bits    = RX_DATA_BITS;
   logic        recv_busy    = 1'b0;
   logic [16:0] recv_count   = '0;
   logic        recv_prev    = 1'b1;
   logic [7:0]  recv_byte    = '0;

   line_state_type due_line_states [$];
   logic           line_plan [$];

   int unsigned failures     = 0;
   int unsigned ticks_sent   = 0;
   int unsigned bytes_queued = 0;
   int unsigned bytes_heard  = 0;
   int unsigned burst_left   = 0;
   int unsigned max_gap      = 2;
   int unsigned hold_len     = 1;
   int unsigned hold_period  = 3;
   int unsigned hold_phase   = 0;
   int unsigned quiet_cycles = 0;

   uart_8n1_timer_transceiver uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_line  (req_rx_line),
      .req_tx_start (req_tx_start),
      .req_tx_byte  (req_tx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_tx_line  (rsp_tx_line),
      .rsp_tx_ready (rsp_tx_ready),
      .rsp_rx_valid (rsp_rx_valid),
      .rsp_rx_byte  (rsp_rx_byte),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // advance the transceiver by one tick and return its outputs
   function automatic line_state_type step_uart(tick_in_type t);
      line_state_type s;
      logic           strobe;
      strobe = 1'b0;
      // transmitter: a request is taken only when idle, no countdown that tick
      if (!xmit_busy) begin
         if (t.tx_start) begin
            xmit_frame = {1'b1, t.tx_byte, 1'b0};
            xmit_bits  = TX_FRAME_BITS;
            xmit_busy  = 1'b1;
            xmit_count = period_ticks;
            bytes_queued++;
         end
      end else if (xmit_count <= 16'd1) begin
         xmit_count = period_ticks;
         if (xmit_bits == 4'd0) begin
            xmit_busy = 1'b0;
            xmit_bits = TX_FRAME_BITS;
         end else begin
            xmit_level = xmit_frame[0];
            xmit_frame = xmit_frame >> 1;
            xmit_bits  = xmit_bits - 4'd1;
         end
      end else begin
         xmit_count = xmit_count - 16'd1;
      end
      // receiver: falling edge arms a 1.5 bit wait, then one sample per bit
      if (!recv_busy) begin
         if (recv_prev && !t.rx_line) begin
            recv_busy  = 1'b1;
            recv_count = {1'b0, period_ticks} + {2'b00, half_ticks};
         end
      end else if (recv_count <= 17'd1) begin
         recv_count = {1'b0, period_ticks};
         recv_shift = {t.rx_line, recv_shift[7:1]};
         recv_bits  = recv_bits - 4'd1;
         if (recv_bits == 4'd0) begin
            recv_byte = recv_shift;
            recv_bits = RX_DATA_BITS;
            recv_busy = 1'b0;
            strobe    = 1'b1;
         end
      end else begin
         recv_count = recv_count - 17'd1;
      end
      recv_prev = t.rx_line;
      s.tx.line  = xmit_level;
      s.tx.ready = !xmit_busy;
      s.rx.valid = strobe;
      s.rx.data  = recv_byte;
      return s;
   endfunction

   // refill the receive line with a frame, a cut frame or noise
   function automatic void plan_line();
      int unsigned width;
      int unsigned kind;
      int unsigned cut;
      logic [9:0]  frame;
      width = (period_ticks < 16'd2) ? 1 : period_ticks;
      kind  = $urandom_range(0, 9);
      if (width > 64 || kind == 0) begin
         repeat ($urandom_range(1, 8)) line_plan.push_back(1'($urandom_range(0, 1)));
         return;
      end
      frame = {1'b1, 8'($urandom), 1'b0};
      cut   = (kind == 1) ? $urandom_range(1, 9) : 10;
      repeat ($urandom_range(0, 2) * width) line_plan.push_back(1'b1);
      for (int b = 0; b < cut; b++) begin
         repeat (width) line_plan.push_back(frame[b]);
      end
   endfunction

   function automatic tick_in_type random_tick();
      tick_in_type t;
      if (line_plan.size() == 0) plan_line();
      t.rx_line  = line_plan.pop_front();
      t.tx_start = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 7))
         0: t.tx_byte = 8'h00;
         1: t.tx_byte = 8'hFF;
         default: t.tx_byte = 8'($urandom);
      endcase
      return t;
   endfunction

   // drive one tick beat, record its outputs once accepted, then maybe pause
   task automatic send_tick(input tick_in_type t, input logic typed,
                            input line_state_type fixed);
      line_state_type predicted;
      int unsigned    gap;
      req_valid    <= 1'b1;
      req_rx_line  <= t.rx_line;
      req_tx_start <= t.tx_start;
      req_tx_byte  <= t.tx_byte;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_uart(t);
      due_line_states.push_back(typed ? fixed : predicted);
      ticks_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, max_gap);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // let every tick in flight come back before touching the registers
   task automatic settle();
      req_valid <= 1'b0;
      while (due_line_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_periods(input logic [15:0] period, input logic [15:0] half_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_BIT_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= half_word;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      period_ticks = period;
      half_ticks   = half_word[14:0];
   endtask

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         failures++;
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      hold_phase <= (hold_phase + 1 >= hold_period) ? 0 : hold_phase + 1;
      rsp_ready  <= (hold_phase >= hold_len);
   end

   // compare each result beat with the oldest predicted tick
   always @(posedge clock) begin
      line_state_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_line_states.size() == 0) begin
            $error("result beat with no tick outstanding");
            failures++;
         end else begin
            want = due_line_states.pop_front();
            check_field("tx_line", 8'(want.tx.line), 8'(rsp_tx_line));
            check_field("tx_ready", 8'(want.tx.ready), 8'(rsp_tx_ready));
            check_field("rx_valid", 8'(want.rx.valid), 8'(rsp_rx_valid));
            check_field("rx_byte", want.rx.data, rsp_rx_byte);
            if (rsp_rx_valid) bytes_heard++;
         end
      end
   end

   // watchdog on stretches with no beat on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no beat accepted for %0d cycles", quiet_cycles);
         $display("[uart_8n1_timer_transceiver] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset periods, then at one tick per bit
      for (int r = 0; r < DRILL_ROWS; r++) begin
         if (r == DRILL_SPLIT) begin
            settle();
            write_periods(16'd1, 16'd1);
         end
         send_tick(drill[r].stim, drill[r].typed, drill[r].want);
      end
      settle();

      // random phases over a spread of bit periods
      phase_plan[6].period    = 16'($urandom_range(2, 8));
      phase_plan[6].half_word = 16'($urandom_range(0, phase_plan[6].period));
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_periods(phase_plan[p].period, phase_plan[p].half_word);
         max_gap     = phase_plan[p].max_gap;
         hold_len    <= phase_plan[p].hold_len;
         hold_period <= phase_plan[p].hold_period;
         line_plan.delete();
         repeat (phase_plan[p].ticks) send_tick(random_tick(), 1'b0, '0);
         settle();
      end

      if (due_line_states.size() != 0) begin
         $error("%0d predicted ticks never came back", due_line_states.size());
         failures++;
      end
      $display("ran %0d ticks over %0d bit period settings, 0 to 65535 ticks per bit",
               ticks_sent, PHASE_COUNT + 2);
      $display("%0d bytes taken for sending, %0d bytes received, %0d mismatches",
               bytes_queued, bytes_heard, failures);
      if (failures == 0) begin
         $display("[uart_8n1_timer_transceiver] OK");
      end else begin
         $display("[uart_8n1_timer_transceiver] ERROR");
      end
      $finish;
   end

endmodule
